[rtl/core/flsa_pkg.sv]
// ----------------------------------------------------------------------------
// Free list slot allocator package
// Result status codes and request kinds shared by the core and the testbench.
// ----------------------------------------------------------------------------
package flsa_pkg;

  // Magnitude bits of a non-negative free offset
  localparam int unsigned OFS_MAG_W = 15;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FREED     = 3'd2,
    ST_DOUBLE    = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

endpackage

[rtl/core/flsa_if.sv]
// ----------------------------------------------------------------------------
// Free list slot allocator channels
// Request channel (alloc or free) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface flsa_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] free_offset;

  modport source (output valid, output kind, output free_offset, input ready);
  modport sink   (input valid, input kind, input free_offset, output ready);
endinterface

interface flsa_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] object_offset;

  modport source (output valid, output status, output object_offset, input ready);
  modport sink   (input valid, input status, input object_offset, output ready);
endinterface

[rtl/core/flsa_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module flsa_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/free_list_slot_allocator.sv]
// ----------------------------------------------------------------------------
// Free list slot allocator
// Fixed-size pool of SLOTS slots kept as a LIFO free list in one RAM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that links every slot into the
// free list (highest slot at the head); it takes no request until that pass
// is done. For each request the accepting cycle reads the slot entry (the
// head for an alloc, the slot decoded from the offset for a free) from the
// slot RAM, and the resolve state then checks it, writes the entry back,
// moves the head and loads the result register. A new request is taken while
// an earlier result still waits in the result register; the resolve state
// stalls only while that register is full and its result is not taken.
// A free offset is decoded to a slot by a multiply with the reciprocal of the
// slot size, checked back with a constant multiply in the resolve state.
// ----------------------------------------------------------------------------
module free_list_slot_allocator #(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned HEADER_BYTES = 8,
  parameter int unsigned OBJECT_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  flsa_req_if.sink   req_i,
  flsa_rsp_if.source rsp_o
);

  localparam int unsigned AW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_BYTES  = HEADER_BYTES + OBJECT_BYTES;
  localparam int unsigned POOL_BYTES  = SLOTS * SLOT_BYTES;
  localparam int unsigned SB_LOG      = $clog2(SLOT_BYTES);
  localparam int unsigned RECIP_SHIFT = flsa_pkg::OFS_MAG_W + SB_LOG;
  localparam int unsigned RECIP       =
    ((32'd1 << RECIP_SHIFT) + SLOT_BYTES - 1) / SLOT_BYTES;
  localparam int unsigned EW          = AW + 2;

  typedef struct packed {
    logic          alloc;
    logic          last;
    logic [AW-1:0] next;
  } slot_entry_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                             state_q;
  logic [AW-1:0]                      clr_q;
  logic [AW-1:0]                      head_q, head_d;
  logic                               empty_q, empty_d;
  flsa_pkg::kind_e                    kind_q;
  logic [flsa_pkg::OFS_MAG_W-1:0]     x_q;
  logic                               range_ok_q;
  logic [AW-1:0]                      slot_q;
  logic                               rsp_valid_q;
  flsa_pkg::status_e                  status_q, status_d;
  logic [7:0]                         obj_q, obj_d;

  logic                               accept;
  logic                               proceed;
  logic [flsa_pkg::OFS_MAG_W-1:0]     x_w;
  logic [47:0]                        prod_w;
  logic [flsa_pkg::OFS_MAG_W-1:0]     quot_w;
  logic [AW-1:0]                      slot_w;
  logic                               range_ok_w;
  logic                               mult_ok;
  slot_entry_t                        entry;
  slot_entry_t                        wentry;
  logic                               ram_we;
  logic                               ram_re;
  logic [AW-1:0]                      ram_waddr;
  logic [AW-1:0]                      ram_raddr;
  logic [EW-1:0]                      ram_rdata;

  // Handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign proceed     = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // Decode the free offset: range check and slot index by reciprocal multiply
  assign x_w    = flsa_pkg::OFS_MAG_W'(req_i.free_offset[14:0] -
                                       flsa_pkg::OFS_MAG_W'(HEADER_BYTES));
  assign prod_w = 48'(x_w) * 48'(RECIP);
  assign quot_w = prod_w[RECIP_SHIFT +: flsa_pkg::OFS_MAG_W];
  assign slot_w = quot_w[AW-1:0];
  assign range_ok_w = !req_i.free_offset[15]
                      && (32'(req_i.free_offset[14:0]) >= 32'(HEADER_BYTES))
                      && (32'(req_i.free_offset[14:0]) < 32'(POOL_BYTES));

  // Issue the entry read with the request
  assign ram_re    = accept;
  assign ram_raddr = (req_i.kind == flsa_pkg::KIND_FREE) ? slot_w : head_q;

  // Offset is a whole number of slots past the first header
  assign mult_ok = (32'(slot_q) * 32'(SLOT_BYTES)) == 32'(x_q);
  assign entry   = slot_entry_t'(ram_rdata);

  // Resolve the request and build the write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    wentry    = '0;
    head_d    = head_q;
    empty_d   = empty_q;
    status_d  = flsa_pkg::ST_INVALID;
    obj_d     = '0;
    case (state_q)
      S_INIT: begin
        ram_we       = 1'b1;
        wentry.alloc = 1'b0;
        wentry.last  = (clr_q == '0);
        wentry.next  = (clr_q == '0) ? '0 : AW'(clr_q - AW'(1));
      end
      S_EXEC: begin
        if (kind_q == flsa_pkg::KIND_ALLOC) begin
          if (empty_q) begin
            status_d = flsa_pkg::ST_EMPTY;
          end else begin
            status_d     = flsa_pkg::ST_ALLOCATED;
            obj_d        = 8'(32'(head_q) * 32'(SLOT_BYTES) + 32'(HEADER_BYTES));
            ram_we       = proceed;
            ram_waddr    = head_q;
            wentry.alloc = 1'b1;
            wentry.last  = entry.last;
            wentry.next  = entry.next;
            if (entry.last) begin
              empty_d = 1'b1;
            end else begin
              head_d = entry.next;
            end
          end
        end else begin
          if (!(range_ok_q && mult_ok)) begin
            status_d = flsa_pkg::ST_INVALID;
          end else if (!entry.alloc) begin
            status_d = flsa_pkg::ST_DOUBLE;
          end else begin
            status_d     = flsa_pkg::ST_FREED;
            ram_we       = proceed;
            ram_waddr    = slot_q;
            wentry.alloc = 1'b0;
            wentry.last  = empty_q;
            wentry.next  = head_q;
            head_d       = slot_q;
            empty_d      = 1'b0;
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Slot entries: allocated flag, end-of-list flag, next link
  flsa_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, list head and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      head_q      <= AW'(SLOTS - 1);
      empty_q     <= 1'b0;
      kind_q      <= flsa_pkg::KIND_ALLOC;
      x_q         <= '0;
      range_ok_q  <= 1'b0;
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= flsa_pkg::ST_ALLOCATED;
      obj_q       <= '0;
    end else begin
      // raise the result on resolve, drop it once taken
      if (proceed) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          clr_q <= AW'(clr_q + AW'(1));
          if (clr_q == AW'(SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q     <= flsa_pkg::kind_e'(req_i.kind);
            x_q        <= x_w;
            range_ok_q <= range_ok_w;
            slot_q     <= slot_w;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (proceed) begin
            head_q      <= head_d;
            empty_q     <= empty_d;
            status_q    <= status_d;
            obj_q       <= obj_d;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.object_offset = obj_q;

  // An accepted request enters the resolve stage in the following cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted request did not enter the resolve stage");

  // Only allocations carry an object offset
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != flsa_pkg::ST_ALLOCATED)) |->
      (rsp_o.object_offset == 8'd0))
    else $error("object offset set on a non-allocation result");

  // An allocation from an empty pool reports empty
  a_empty_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proceed && (kind_q == flsa_pkg::KIND_ALLOC) && empty_q) |=>
      (rsp_o.valid && (rsp_o.status == flsa_pkg::ST_EMPTY)))
    else $error("allocation from an empty pool not reported as empty");

  // No slot entry is written between requests
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("slot RAM written while idle");

endmodule

[tb/free_list_slot_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list slot allocator testbench
// Sends alloc and free requests through the request channel, first from a
// short table of corner cases and then at random. A local copy of the free
// list works out the expected results the table leaves open. Results are
// compared in order, field by field. Both channels idle at random; the result
// side holds off once for a long stretch so the block fills up and backs up its input.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_tb;

  localparam int SLOTS          = 16;
  localparam int HEADER_BYTES   = 8;
  localparam int OBJECT_BYTES   = 8;
  localparam int SLOT_BYTES     = HEADER_BYTES + OBJECT_BYTES;
  localparam int POOL_BYTES     = SLOTS * SLOT_BYTES;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    flsa_pkg::status_e status;
    logic [7:0]        obj;
  } result_t;

  typedef struct {
    flsa_pkg::kind_e    kind;
    logic signed [15:0] ofs;
    int                 reps;
    bit                 typed;
    flsa_pkg::status_e  status;
    logic [7:0]         obj;
  } drill_row_t;

  logic clk_i;
  logic rst_ni;

  flsa_req_if req_if ();
  flsa_rsp_if rsp_if ();

  free_list_slot_allocator #(
    .SLOTS        (SLOTS),
    .HEADER_BYTES (HEADER_BYTES),
    .OBJECT_BYTES (OBJECT_BYTES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Local copy of the free list
  int head_slot;
  int next_slot [SLOTS];
  bit end_mark [SLOTS];
  bit slot_taken [SLOTS];
  bit pool_dry;

  result_t expected_q [$];
  int      error_count;
  int      results_seen;
  int      quiet_cycles;
  bit      sender_calm;
  result_t seen;

  // Corner cases; rows with typed results are checked against the table
  drill_row_t drill_rows [0:23] = '{
    '{flsa_pkg::KIND_FREE,  16'sd8,    1,  1'b1, flsa_pkg::ST_DOUBLE,    8'd0},   // never out
    '{flsa_pkg::KIND_FREE,  16'sh8000, 1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // most neg
    '{flsa_pkg::KIND_FREE,  16'sh7fff, 1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // most pos
    '{flsa_pkg::KIND_FREE,  16'sd0,    1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // pool base
    '{flsa_pkg::KIND_FREE,  16'sd7,    1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // in header
    '{flsa_pkg::KIND_FREE,  16'sd9,    1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // misaligned
    '{flsa_pkg::KIND_FREE,  16'sd264,  1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // past pool
    '{flsa_pkg::KIND_FREE,  -16'sd8,   1,  1'b1, flsa_pkg::ST_INVALID,   8'd0},   // negative
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_ALLOCATED, 8'd248}, // top slot
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_ALLOCATED, 8'd232},
    '{flsa_pkg::KIND_FREE,  16'sd248,  1,  1'b1, flsa_pkg::ST_FREED,     8'd0},
    '{flsa_pkg::KIND_FREE,  16'sd248,  1,  1'b1, flsa_pkg::ST_DOUBLE,    8'd0},   // again
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_ALLOCATED, 8'd248}, // LIFO
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    13, 1'b0, flsa_pkg::ST_ALLOCATED, 8'd0},
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_ALLOCATED, 8'd8},   // drains
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_EMPTY,     8'd0},
    '{flsa_pkg::KIND_FREE,  16'sd8,    1,  1'b1, flsa_pkg::ST_FREED,     8'd0},   // to empty
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_ALLOCATED, 8'd8},
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b1, flsa_pkg::ST_EMPTY,     8'd0},
    '{flsa_pkg::KIND_FREE,  16'sd24,   1,  1'b0, flsa_pkg::ST_FREED,     8'd0},
    '{flsa_pkg::KIND_FREE,  16'sd248,  1,  1'b0, flsa_pkg::ST_FREED,     8'd0},
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    2,  1'b0, flsa_pkg::ST_ALLOCATED, 8'd0},
    '{flsa_pkg::KIND_FREE,  16'sd120,  1,  1'b0, flsa_pkg::ST_FREED,     8'd0},
    '{flsa_pkg::KIND_ALLOC, 16'sd0,    1,  1'b0, flsa_pkg::ST_ALLOCATED, 8'd0}
  };

  // Work out the result of one request and advance the local free list
  function automatic result_t predict_result(flsa_pkg::kind_e kind,
                                             logic signed [15:0] ofs);
    result_t r;
    int      byte_ofs;
    int      s;
    int      obj_full;
    r.status = flsa_pkg::ST_INVALID;
    r.obj    = 8'd0;
    if (kind == flsa_pkg::KIND_ALLOC) begin
      if (pool_dry) begin
        r.status = flsa_pkg::ST_EMPTY;
      end else begin
        s        = head_slot;
        obj_full = s * SLOT_BYTES + HEADER_BYTES;
        r.status = flsa_pkg::ST_ALLOCATED;
        r.obj    = obj_full[7:0];
        if (end_mark[s]) begin
          pool_dry = 1'b1;
        end else begin
          head_slot = next_slot[s];
        end
        slot_taken[s] = 1'b1;
      end
    end else begin
      byte_ofs = int'(ofs);
      if (byte_ofs >= HEADER_BYTES && byte_ofs < POOL_BYTES &&
          (byte_ofs - HEADER_BYTES) % SLOT_BYTES == 0) begin
        s = (byte_ofs - HEADER_BYTES) / SLOT_BYTES;
        if (!slot_taken[s]) begin
          r.status = flsa_pkg::ST_DOUBLE;
        end else begin
          next_slot[s]  = head_slot;
          end_mark[s]   = pool_dry;
          head_slot     = s;
          pool_dry      = 1'b0;
          slot_taken[s] = 1'b0;
          r.status      = flsa_pkg::ST_FREED;
        end
      end
    end
    return r;
  endfunction

  task automatic log_failure(input string msg);
    if (error_count < REPORT_LIMIT) begin
      $display("%t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Offer one request after a random gap (none while calm), then queue its expected result
  task automatic offer_request(input flsa_pkg::kind_e kind,
                               input logic signed [15:0] ofs,
                               input bit typed, input result_t typed_result);
    result_t predicted;
    while (!sender_calm && $urandom_range(99) < 35) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.free_offset <= ofs;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    predicted = predict_result(kind, ofs);
    expected_q.push_back(typed ? typed_result : predicted);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Reset, then the free list as it stands after reset
  initial begin
    rst_ni = 1'b0;
    head_slot = SLOTS - 1;
    for (int s = 0; s < SLOTS; s++) begin
      next_slot[s]  = (s == 0) ? 0 : s - 1;
      end_mark[s]   = (s == 0);
      slot_taken[s] = 1'b0;
    end
    pool_dry = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request side: table first, then random requests
  initial begin
    int                 alloc_pct;
    int                 dice;
    int                 held_slots [$];
    flsa_pkg::kind_e    kind;
    logic signed [15:0] ofs;
    result_t            row_result;
    error_count        = 0;
    results_seen       = 0;
    sender_calm        = 1'b0;
    alloc_pct          = 50;
    req_if.valid       <= 1'b0;
    req_if.kind        <= flsa_pkg::KIND_ALLOC;
    req_if.free_offset <= '0;
    wait (rst_ni);
    @(posedge clk_i);

    foreach (drill_rows[i]) begin
      row_result.status = drill_rows[i].status;
      row_result.obj    = drill_rows[i].obj;
      repeat (drill_rows[i].reps) begin
        offer_request(drill_rows[i].kind, drill_rows[i].ofs, drill_rows[i].typed,
                      row_result);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Swing the alloc share so the pool runs both full and dry
      if (n % 40 == 0) begin
        alloc_pct = $urandom_range(15, 85);
      end
      sender_calm = (n >= 500 && n < 700);
      held_slots.delete();
      foreach (slot_taken[s]) begin
        if (slot_taken[s]) held_slots.push_back(s);
      end
      dice = $urandom_range(99);
      kind = flsa_pkg::KIND_FREE;
      ofs  = 16'($urandom_range(65535));
      if (dice < alloc_pct) begin
        kind = flsa_pkg::KIND_ALLOC;
      end else if (dice < 92 && held_slots.size() > 0) begin
        ofs = 16'(held_slots[$urandom_range(held_slots.size() - 1)] * SLOT_BYTES
                  + HEADER_BYTES);
      end else begin
        // Noise: any offset, any slot, off by a little, or past the pool
        case ($urandom_range(3))
          1: ofs = 16'($urandom_range(SLOTS - 1) * SLOT_BYTES + HEADER_BYTES);
          2: ofs = 16'($urandom_range(SLOTS - 1) * SLOT_BYTES + HEADER_BYTES
                       + $urandom_range(1, SLOT_BYTES - 1));
          3: ofs = 16'(POOL_BYTES + HEADER_BYTES + $urandom_range(15) * SLOT_BYTES);
          default: ;
        endcase
      end
      offer_request(kind, ofs, 1'b0, row_result);
    end
    sender_calm  = 1'b0;
    req_if.valid <= 1'b0;

    // Drain outstanding results, then let the pipe settle
    while (expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("free_list_slot_allocator regression: pass");
    end else begin
      $display("free_list_slot_allocator regression: fail");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off and a calm stretch
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!held && results_seen >= 300) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (results_seen >= 700 && results_seen < 900) ||
                        ($urandom_range(99) >= 35);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        log_failure($sformatf("result with nothing expected: status %0d obj %0d",
                              rsp_if.status, rsp_if.object_offset));
      end else begin
        seen = expected_q.pop_front();
        if (rsp_if.status !== seen.status) begin
          log_failure($sformatf("status mismatch: expected %0d, got %0d",
                                seen.status, rsp_if.status));
        end
        if (rsp_if.object_offset !== seen.obj) begin
          log_failure($sformatf("object offset mismatch: expected %0d, got %0d",
                                seen.obj, rsp_if.object_offset));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("free_list_slot_allocator regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule

[sim.f]
rtl/core/flsa_pkg.sv
rtl/core/flsa_if.sv
rtl/core/flsa_ram.sv
rtl/core/free_list_slot_allocator.sv
tb/free_list_slot_allocator_tb.sv
